// ----- rtl/lkvc_pkg.sv -----
// ----------------------------------------------------------------------------
// lkvc_pkg
// shared types and constants for the lru key-value cache
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int KEY_W       = 32;
  localparam int DATA_W      = 32;
  localparam int CAP_W       = 5;
  localparam int ENTRIES_DEF = 16;

  localparam logic [CAP_W-1:0]  CAP_RESET = 5'd16;
  localparam logic [DATA_W-1:0] DATA_MISS = {DATA_W{1'b1}};
  localparam logic [DATA_W-1:0] DATA_NONE = '0;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_SET = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                     command;
    logic signed [KEY_W-1:0]  key;
    logic signed [DATA_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] data;
  } out_beat_t;

endpackage

// ----- rtl/lru_key_value_cache_top.sv -----
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// fully associative key-value cache with least-recently-used replacement
// the input beat is registered in in_r and its result is registered in out_r
// throughput: one beat per cycle unless out_ready stalls; all entries are
// compared in parallel; ranks, store and occupancy update in the same cycle
// reset: store empty, occupancy zero, capacity 16; key and value storage is
// not cleared and no clearing pass is run
// ----------------------------------------------------------------------------
module lru_key_value_cache_top #(
  parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  lkvc_pkg::in_beat_t             in_beat,
  output logic                           out_valid,
  input  logic                           out_ready,
  output lkvc_pkg::out_beat_t            out_beat,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lkvc_pkg::CAP_W-1:0]     cfg_capacity
);
  import lkvc_pkg::*;

  localparam int RK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [CAP_W-1:0]  capacity_r;
  in_beat_t          in_r;
  logic              in_valid_r;
  out_beat_t         out_r, out_nxt;
  logic              out_valid_r;
  logic              advance;

  logic [KEY_W-1:0]  key_r   [ENTRIES];
  logic [KEY_W-1:0]  key_nxt [ENTRIES];
  logic [DATA_W-1:0] val_r   [ENTRIES];
  logic [DATA_W-1:0] val_nxt [ENTRIES];
  logic [RK_W-1:0]   rank_r  [ENTRIES];
  logic [RK_W-1:0]   rank_nxt[ENTRIES];
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]  occ_r, occ_nxt;

  logic [ENTRIES-1:0] match, evict, valid_kept, free_sel;
  logic               any_hit, any_free, found, do_evict;
  logic [DATA_W-1:0]  hit_val;
  logic [RK_W-1:0]    hit_rank;
  logic [CMP_W-1:0]   cap_eff;

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

  // effective capacity, clamped to 1..ENTRIES
  always_comb begin
    cap_eff = CMP_W'(capacity_r);
    if (cap_eff == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_eff > CMP_W'(ENTRIES)) begin
      cap_eff = CMP_W'(ENTRIES);
    end
  end

  // parallel lookup
  always_comb begin
    hit_val  = '0;
    hit_rank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_r[i] && (key_r[i] == in_r.key);
      if (match[i]) begin
        hit_val  = hit_val | val_r[i];
        hit_rank = hit_rank | rank_r[i];
      end
    end
    any_hit = |match;
  end

  // victim and free slot for an insertion
  always_comb begin
    do_evict = CMP_W'(occ_r) >= cap_eff;
    for (int i = 0; i < ENTRIES; i++) begin
      evict[i] = do_evict && valid_r[i] && (CNT_W'(rank_r[i]) == occ_r - CNT_W'(1));
    end
    valid_kept = valid_r & ~evict;
    found      = 1'b0;
    free_sel   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!valid_kept[i] && !found) begin
        free_sel[i] = 1'b1;
        found       = 1'b1;
      end
    end
    any_free = found;
  end

  // next state of the store
  always_comb begin
    valid_nxt = valid_r;
    occ_nxt   = occ_r;
    for (int i = 0; i < ENTRIES; i++) begin
      key_nxt[i]  = key_r[i];
      val_nxt[i]  = val_r[i];
      rank_nxt[i] = rank_r[i];
    end
    if (any_hit) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_r[i] && rank_r[i] < hit_rank) begin
          rank_nxt[i] = rank_r[i] + RK_W'(1);
        end
        if (match[i]) begin
          rank_nxt[i] = '0;
          if (in_r.command == CMD_SET) begin
            val_nxt[i] = in_r.value;
          end
        end
      end
    end else if (in_r.command == CMD_SET && any_free) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_kept[i]) begin
          rank_nxt[i] = rank_r[i] + RK_W'(1);
        end
        if (evict[i] || free_sel[i]) begin
          rank_nxt[i] = '0;
        end
        if (free_sel[i]) begin
          key_nxt[i] = in_r.key;
          val_nxt[i] = in_r.value;
        end
      end
      valid_nxt = valid_kept | free_sel;
      occ_nxt   = occ_r - CNT_W'(do_evict) + CNT_W'(1);
    end
  end

  // result
  always_comb begin
    out_nxt.hit = any_hit;
    if (in_r.command == CMD_GET) begin
      out_nxt.data = any_hit ? hit_val : DATA_MISS;
    end else begin
      out_nxt.data = DATA_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r  <= CAP_RESET;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      occ_r       <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity_r <= cfg_capacity;
      end
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        valid_r     <= valid_nxt;
        occ_r       <= occ_nxt;
        for (int i = 0; i < ENTRIES; i++) begin
          rank_r[i] <= rank_nxt[i];
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_beat;
    end
    if (advance) begin
      out_r <= out_nxt;
      for (int i = 0; i < ENTRIES; i++) begin
        key_r[i] <= key_nxt[i];
        val_r[i] <= val_nxt[i];
      end
    end
  end

endmodule
